/* rtl/core/assert_macros.svh */
// Assertion macros shared by the RTL of the servo pulse generator.
// Depends on a clock named clk_i and an active-low reset named rst_ni in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SVPG_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("servo pulse generator: same-cycle check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define SVPG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("servo pulse generator: next-cycle check failed");

`endif

/* rtl/core/svpg_pkg.sv */
// Shared types, constants and helper functions for the servo pulse generator.
// No dependencies; imported by every module of the block.
package svpg_pkg;

  localparam int unsigned CHANNELS_DEF = 6;
  localparam int unsigned PIN_W        = 6;
  localparam int unsigned TICK_W       = 13;
  localparam int unsigned POS_W        = 8;
  localparam int unsigned PROD_W       = 2 * POS_W;
  localparam int unsigned CFG_DATA_W   = TICK_W;
  localparam int unsigned CFG_IDX_W    = 2;

  localparam logic [POS_W-1:0]  POS_MAX          = 8'd255;
  localparam logic [TICK_W-1:0] FRAME_TICKS_RST  = 13'd5000;
  localparam logic [7:0]        BASE_TICKS_RST   = 8'd100;
  localparam logic [7:0]        SPAN_TICKS_RST   = 8'd100;
  localparam logic [PIN_W-1:0]  INVERT_MASK_RST  = 6'd42;

  typedef enum logic {
    FUNC_TICK = 1'b0,
    FUNC_LOAD = 1'b1
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_TICKS = 2'd0,
    CFG_BASE_TICKS  = 2'd1,
    CFG_SPAN_TICKS  = 2'd2,
    CFG_INVERT_MASK = 2'd3
  } cfg_idx_e;

  // Pulse shape settings common to every channel.
  typedef struct packed {
    logic [7:0] base;
    logic [7:0] span;
  } lane_cfg_t;

  // Exact floor(x / 255) for any 16-bit x up to 255 * 255, using x/255 ~ (x + x/256 + 1) / 256.
  function automatic logic [POS_W-1:0] div255(input logic [PROD_W-1:0] x);
    logic [PROD_W:0] t;
    t = {1'b0, x} + (PROD_W+1)'(x >> POS_W) + (PROD_W+1)'(1);
    return t[PROD_W-1:POS_W];
  endfunction

endpackage

/* rtl/core/svpg_lane.sv */
// One channel of the servo pulse generator: pulse end from position and the pin compare.
// Depends on svpg_pkg for widths, the settings struct and the divide-by-255 helper.
module svpg_lane import svpg_pkg::*; (
  input  lane_cfg_t         cfg_i,
  input  logic              invert_i,
  input  logic [POS_W-1:0]  position_i,
  input  logic [TICK_W-1:0] tick_count_i,
  output logic              pin_o
);

  logic [POS_W-1:0]  pos_eff;
  logic [PROD_W-1:0] prod;
  logic [POS_W-1:0]  extra;
  logic [POS_W:0]    pulse_end;

  // A mirrored channel runs from the long end of the range.
  assign pos_eff   = invert_i ? (POS_MAX - position_i) : position_i;
  assign prod      = PROD_W'(cfg_i.span) * PROD_W'(pos_eff);
  assign extra     = div255(prod);
  assign pulse_end = {1'b0, cfg_i.base} + {1'b0, extra};
  assign pin_o     = tick_count_i < TICK_W'(pulse_end);

endmodule

/* rtl/core/multi_channel_servo_pulse_generator.sv */
// Top level of the multi-channel hobby-servo pulse generator.
// Depends on svpg_pkg, svpg_lane and the assertion macros in assert_macros.svh.
`include "assert_macros.svh"

// The block takes one word per clock cycle on the input channel, either a tick of the
// 10 us time base or a load of one channel's 8-bit position, and returns one word with
// the six pin levels and a frame-start flag for every tick; loads return nothing. Each
// word passes through an input register and, for a tick, goes on into a result
// register, so one word per cycle is sustained as long as the result side keeps
// taking words; a load never waits for the result side, and a tick waits only while the
// result register is full and stalled. Loaded positions stay pending until the first
// tick of the next frame, when all of them become active together. A pin is high while
// the tick count within the frame is below base + span * position / 255, with the
// position mirrored as 255 minus its value for channels whose invert bit is set. The
// four settings (frame length, base, span and invert mask) are written through the
// configuration port, which is always ready, and should only be changed while the block
// is idle.
module multi_channel_servo_pulse_generator import svpg_pkg::*; #(
  parameter int unsigned CHANNELS = CHANNELS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Input words.
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  func_i,
  input  logic [2:0]            channel_i,
  input  logic [POS_W-1:0]      position_i,
  // Result words.
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [PIN_W-1:0]      pins_o,
  output logic                  frame_start_o,
  // Configuration writes.
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // Only the channels that reach a pin need storage; loads to any other channel are
  // dropped.
  localparam int unsigned LANES = (CHANNELS < PIN_W) ? CHANNELS : PIN_W;

  // Configuration registers.
  logic [TICK_W-1:0] frame_ticks_q;
  logic [7:0]        base_ticks_q;
  logic [7:0]        span_ticks_q;
  logic [PIN_W-1:0]  invert_mask_q;

  // Input register.
  logic              s1_valid_q;
  func_e             s1_func_q;
  logic [2:0]        s1_channel_q;
  logic [POS_W-1:0]  s1_position_q;

  // Frame state.
  logic [TICK_W-1:0] tick_count_q;
  logic [TICK_W-1:0] tick_count_d;
  logic [TICK_W:0]   count_inc;
  logic [POS_W-1:0]  pend_q   [LANES];
  logic [POS_W-1:0]  active_q [LANES];
  logic [POS_W-1:0]  active_eff [LANES];

  // Result register.
  logic              out_valid_q;
  logic [PIN_W-1:0]  pins_q;
  logic              frame_start_q;

  logic              s1_adv;
  logic              in_acc;
  logic              tick_adv;
  logic              load_adv;
  logic              frame_start;
  logic [LANES-1:0]  lane_pin;
  lane_cfg_t         lane_cfg;

  // The configuration port never pushes back.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_ticks_q <= FRAME_TICKS_RST;
      base_ticks_q  <= BASE_TICKS_RST;
      span_ticks_q  <= SPAN_TICKS_RST;
      invert_mask_q <= INVERT_MASK_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_FRAME_TICKS: frame_ticks_q <= cfg_data_i;
        CFG_BASE_TICKS:  base_ticks_q  <= cfg_data_i[7:0];
        CFG_SPAN_TICKS:  span_ticks_q  <= cfg_data_i[7:0];
        CFG_INVERT_MASK: invert_mask_q <= cfg_data_i[PIN_W-1:0];
      endcase
    end
  end

  // A load always leaves the input register at once, since it produces no result. A tick
  // leaves when the result register is empty or is being emptied in the same cycle.
  assign s1_adv     = s1_valid_q && ((s1_func_q == FUNC_LOAD) || !out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign tick_adv   = s1_adv && (s1_func_q == FUNC_TICK);
  assign load_adv   = s1_adv && (s1_func_q == FUNC_LOAD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_func_q     <= func_e'(func_i);
      s1_channel_q  <= channel_i;
      s1_position_q <= position_i;
    end
  end

  // The first tick of a frame sees the pending positions directly, as they become
  // active on that very tick.
  assign frame_start = (tick_count_q == '0);

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      active_eff[i] = frame_start ? pend_q[i] : active_q[i];
    end
  end

  // The count wraps once the advanced value reaches the frame length, which also covers
  // a frame length lowered below the current count.
  assign count_inc    = {1'b0, tick_count_q} + (TICK_W+1)'(1);
  assign tick_count_d = (count_inc >= {1'b0, frame_ticks_q}) ? '0 : count_inc[TICK_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_count_q <= '0;
      for (int i = 0; i < LANES; i++) begin
        pend_q[i]   <= '0;
        active_q[i] <= '0;
      end
    end else begin
      if (tick_adv) begin
        tick_count_q <= tick_count_d;
      end
      for (int i = 0; i < LANES; i++) begin
        if (load_adv && (s1_channel_q == 3'(i))) begin
          pend_q[i] <= s1_position_q;
        end
        if (tick_adv && frame_start) begin
          active_q[i] <= active_eff[i];
        end
      end
    end
  end

  assign lane_cfg.base = base_ticks_q;
  assign lane_cfg.span = span_ticks_q;

  for (genvar g = 0; g < LANES; g++) begin : gen_lane
    svpg_lane u_lane (
      .cfg_i        (lane_cfg),
      .invert_i     (invert_mask_q[g]),
      .position_i   (active_eff[g]),
      .tick_count_i (tick_count_q),
      .pin_o        (lane_pin[g])
    );
  end

  // The result register fills on every tick that leaves the input register and empties
  // when the receiver takes the word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (tick_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_adv) begin
      pins_q        <= PIN_W'(lane_pin);
      frame_start_q <= frame_start;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pins_o        = pins_q;
  assign frame_start_o = frame_start_q;

  // Every tick that leaves the input register shows up as a result in the next cycle.
  `SVPG_ASSERT_NEXT(a_tick_gives_result, tick_adv, out_valid_o)
  // A tick at count zero is reported as the start of a frame.
  `SVPG_ASSERT_NEXT(a_frame_start_flag, tick_adv && frame_start, frame_start_o)
  // The input side is held back only by a tick waiting on a full, stalled result register.
  `SVPG_ASSERT_IMP(a_stall_cause, in_stall_o,
                   s1_valid_q && (s1_func_q == FUNC_TICK) && out_valid_o && out_stall_i)

endmodule
